@@ hw/rtl/mwiw_pkg.sv @@
// ----------------------------------------------------------------------------
// Missed-wakeup watchdog package
// Shared constants, opcode and register codes, and the structs that pass
// between the top level and the per-core cells.
// ----------------------------------------------------------------------------
package mwiw_pkg;

    localparam int MAX_CORES     = 8;
    localparam int NUM_CORES_DEF = 8;

    localparam int OPCODE_W = 2;
    localparam int CORE_W   = 3;
    localparam int STAMP_W  = 63;
    localparam int MASK_W   = 8;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] LATENCY_RESET = 32'd3500000;
    localparam logic [CFG_W-1:0] RESEND_RESET  = 32'd1000000000;

    localparam logic [CFG_IDX_W-1:0] REG_LATENCY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESEND  = 1'd1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ENTER = 2'd0,
        OP_EXIT  = 2'd1,
        OP_CHECK = 2'd2
    } opcode_t;

    // A check item as it travels from cell to cell.
    typedef struct packed {
        logic               vld;
        logic [STAMP_W-1:0] now;
        logic [MASK_W-1:0]  online;
        logic [MASK_W-1:0]  pending;
        logic [MASK_W-1:0]  resend;
    } carry_t;

    // A power event, broadcast to every cell.
    typedef struct packed {
        logic              vld;
        logic              enter;
        logic [CORE_W-1:0] core;
    } evt_t;

endpackage

@@ hw/rtl/mwiw_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Carries one event or check item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mwiw_req_if;
    logic                                valid;
    logic                                ready;
    logic [mwiw_pkg::OPCODE_W-1:0]       opcode;
    logic [mwiw_pkg::CORE_W-1:0]         core_index;
    logic [mwiw_pkg::STAMP_W-1:0]        now_time;
    logic [mwiw_pkg::MASK_W-1:0]         online_mask;
    logic [mwiw_pkg::MASK_W-1:0]         pending_mask;

    modport source (output valid, opcode, core_index, now_time, online_mask,
                    pending_mask, input ready);
    modport sink   (input valid, opcode, core_index, now_time, online_mask,
                    pending_mask, output ready);
endinterface

@@ hw/rtl/mwiw_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Carries the resend mask of one item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mwiw_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mwiw_pkg::MASK_W-1:0]   resend_mask;

    modport source (output valid, resend_mask, input ready);
    modport sink   (input valid, resend_mask, output ready);
endinterface

@@ hw/rtl/mwiw_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mwiw_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mwiw_pkg::CFG_IDX_W-1:0]  index;
    logic [mwiw_pkg::CFG_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/missed_wakeup_ipi_watchdog_core.sv @@
// ----------------------------------------------------------------------------
// Missed-wakeup interrupt watchdog
// A row of per-core cells; a check item walks the row one core per cycle.
// ----------------------------------------------------------------------------
// Path: a check item passes each core cell in turn, then the result stage and
// the output register before it shows on the response channel; a power event
// or an unused opcode passes only the result stage and the output register.
// One item at a time: the next item is taken only once the previous one has
// left the cell row and the result stage; a stalled output side holds it back.
// Reset clears the power-down mask and all stamps and loads the default limits.
// ----------------------------------------------------------------------------
module missed_wakeup_ipi_watchdog_core #(
    parameter int NUM_CORES = mwiw_pkg::NUM_CORES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mwiw_req_if.sink   req,
    mwiw_rsp_if.source rsp,
    mwiw_cfg_if.sink   cfg
);

    // Only as many cores as the masks can describe get a cell.
    localparam int ACTIVE = (NUM_CORES < mwiw_pkg::MAX_CORES) ?
                            NUM_CORES : mwiw_pkg::MAX_CORES;

    logic [mwiw_pkg::CFG_W-1:0]  latency_reg, latency_next;
    logic [mwiw_pkg::CFG_W-1:0]  interval_reg, interval_next;
    logic                        res_valid_reg, res_valid_next;
    logic [mwiw_pkg::MASK_W-1:0] res_mask_reg, res_mask_next;
    logic                        out_valid_reg, out_valid_next;
    logic [mwiw_pkg::MASK_W-1:0] out_mask_reg, out_mask_next;

    mwiw_pkg::carry_t carry [ACTIVE+1];
    mwiw_pkg::evt_t   evt;
    logic [ACTIVE-1:0] cell_busy;
    logic              busy;
    logic              accept;
    logic              out_free;

    // ------------------------------------------------------------------
    // Configuration registers. The user must write only while the block is idle; the block itself does not enforce it.
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_comb
    begin
        latency_next  = latency_reg;
        interval_next = interval_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                mwiw_pkg::REG_LATENCY: latency_next  = cfg.data;
                mwiw_pkg::REG_RESEND:  interval_next = cfg.data;
                default:               latency_next  = latency_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Intake. The block holds one item at a time: a new one is taken when no
    // check is walking the row and the result stage is empty. The output
    // register may still hold an older result while this happens.
    // ------------------------------------------------------------------
    assign busy      = (|cell_busy) || res_valid_reg;
    assign req.ready = !busy;
    assign accept    = req.valid && req.ready;

    // A power event goes to all cells at once; only the addressed one acts.
    // A core index with no cell matches nothing and is dropped.
    always_comb
    begin
        evt.vld   = accept && ((req.opcode == mwiw_pkg::OP_ENTER)
                               || (req.opcode == mwiw_pkg::OP_EXIT));
        evt.enter = (req.opcode == mwiw_pkg::OP_ENTER);
        evt.core  = req.core_index;
    end

    // A check enters the first cell with an empty resend mask.
    always_comb
    begin
        carry[0].vld     = accept && (req.opcode == mwiw_pkg::OP_CHECK);
        carry[0].now     = req.now_time;
        carry[0].online  = req.online_mask;
        carry[0].pending = req.pending_mask;
        carry[0].resend  = '0;
    end

    // ------------------------------------------------------------------
    // The row of cells, one per core.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < ACTIVE; i++)
    begin : g_cell
        mwiw_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .evt       (evt),
            .latency   (latency_reg),
            .interval  (interval_reg),
            .carry_in  (carry[i]),
            .carry_out (carry[i+1])
        );
        assign cell_busy[i] = carry[i+1].vld;
    end

    // ------------------------------------------------------------------
    // Result stage and output register. The result stage takes the mask of
    // a finished check, or a zero mask for any other item, and passes it on
    // as soon as the output register is free.
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_mask_next  = res_mask_reg;
        if (res_valid_reg && out_free)
        begin
            res_valid_next = 1'b0;
        end
        if (carry[ACTIVE].vld)
        begin
            res_valid_next = 1'b1;
            res_mask_next  = carry[ACTIVE].resend;
        end
        else if (accept && (req.opcode != mwiw_pkg::OP_CHECK))
        begin
            res_valid_next = 1'b1;
            res_mask_next  = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_mask_next  = out_mask_reg;
        if (out_free)
        begin
            out_valid_next = res_valid_reg;
            out_mask_next  = res_mask_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.resend_mask = out_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latency_reg   <= mwiw_pkg::LATENCY_RESET;
            interval_reg  <= mwiw_pkg::RESEND_RESET;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            latency_reg   <= latency_next;
            interval_reg  <= interval_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_mask_reg <= res_mask_next;
        out_mask_reg <= out_mask_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // At most one check walks the row at any time.
    a_one_check: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_busy))
        else $error("more than one check item in the cell row");

    // A check leaving the row always finds the result stage empty.
    a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
        carry[ACTIVE].vld |-> !res_valid_reg)
        else $error("check result would overwrite a waiting result");

    // Any item other than a check yields a zero mask in the next cycle.
    a_evt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.opcode != mwiw_pkg::OP_CHECK))
        |=> (res_valid_reg && (res_mask_reg == '0)))
        else $error("non-check item did not produce a zero result");

    // An accepted check reaches the last cell after passing each cell in turn.
    a_check_walk: assert property (@(posedge clk) disable iff (!rst_n)
        carry[0].vld |-> ##ACTIVE carry[ACTIVE].vld)
        else $error("check item lost in the cell row");

endmodule

@@ hw/rtl/mwiw_cell.sv @@
// ----------------------------------------------------------------------------
// Watchdog cell
// Holds one core's power-down bit and stamps, evaluates a passing check
// item and hands it on to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module mwiw_cell #(
    parameter int IDX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mwiw_pkg::evt_t                evt,
    input  logic [mwiw_pkg::CFG_W-1:0]    latency,
    input  logic [mwiw_pkg::CFG_W-1:0]    interval,
    input  mwiw_pkg::carry_t              carry_in,
    output mwiw_pkg::carry_t              carry_out
);

    localparam int SUM_W = mwiw_pkg::STAMP_W + 1;

    logic                          pd_reg, pd_next;
    logic [mwiw_pkg::STAMP_W-1:0]  pstamp_reg, pstamp_next;
    logic [mwiw_pkg::STAMP_W-1:0]  sstamp_reg, sstamp_next;
    logic                          cvld_reg, cvld_next;
    mwiw_pkg::carry_t              cdat_reg, cdat_next;

    logic             hit_evt;
    logic             visit;
    logic             suspect;
    logic             resend;
    logic [SUM_W-1:0] now_ext;
    logic [SUM_W-1:0] pend_lim;
    logic [SUM_W-1:0] sent_lim;

    assign hit_evt  = evt.vld && (evt.core == mwiw_pkg::CORE_W'(IDX));
    assign visit    = carry_in.vld && pd_reg && carry_in.online[IDX]
                      && carry_in.pending[IDX];
    assign now_ext  = {1'b0, carry_in.now};
    assign pend_lim = {1'b0, pstamp_reg} + SUM_W'(latency);
    assign sent_lim = {1'b0, sstamp_reg} + SUM_W'(interval);
    assign suspect  = (pstamp_reg != '0) && (now_ext > pend_lim);
    assign resend   = visit && suspect
                      && ((sstamp_reg == '0) || (now_ext > sent_lim));

    always_comb
    begin
        pd_next     = pd_reg;
        pstamp_next = pstamp_reg;
        sstamp_next = sstamp_reg;
        if (hit_evt)
        begin
            // Entering or leaving power-down both start the stamps afresh.
            pd_next     = evt.enter;
            pstamp_next = '0;
            sstamp_next = '0;
        end
        else if (visit)
        begin
            pstamp_next = carry_in.now;
            if (resend)
            begin
                sstamp_next = carry_in.now;
            end
        end
        cvld_next        = carry_in.vld;
        cdat_next        = carry_in;
        cdat_next.resend = carry_in.resend | (mwiw_pkg::MASK_W'(resend) << IDX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pd_reg     <= 1'b0;
            pstamp_reg <= '0;
            sstamp_reg <= '0;
            cvld_reg   <= 1'b0;
        end
        else
        begin
            pd_reg     <= pd_next;
            pstamp_reg <= pstamp_next;
            sstamp_reg <= sstamp_next;
            cvld_reg   <= cvld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cdat_reg <= cdat_next;
    end

    always_comb
    begin
        carry_out     = cdat_reg;
        carry_out.vld = cvld_reg;
    end

endmodule
